### hw/rtl/kls_pkg.sv
// Shared types and constants for the k-th largest selector.
// Used by kls_cell, kls_out_buf, kth_largest_select, kls_checker and testbench; no dependencies.
package kls_pkg;

  localparam int unsigned VALUE_W = 32;
  localparam int unsigned RANK_W  = 7;

  localparam logic [RANK_W-1:0] RANK_RESET = RANK_W'(1);

  // What one cell shows its right-hand neighbor
  typedef struct packed {
    logic                      keep;   // entry stays in place for the incoming value
    logic                      valid;  // entry holds a value of the current set
    logic signed [VALUE_W-1:0] entry;
  } link_t;

  // One finished result
  typedef struct packed {
    logic                      enough;
    logic signed [VALUE_W-1:0] kth_value;
  } result_t;

endpackage

### hw/rtl/kth_largest_select.sv
// Top level of the k-th largest selector: cell chain, rank register, result selection.
// Depends on kls_pkg, kls_cell and kls_out_buf.
//
// Usage:
//   s_axis carries one signed 32-bit value per request; tlast marks the last
//   value of a data set. Each value is inserted into a row of MAX_RANK cells
//   that keep the largest values in descending order, one value per cycle.
//   On a request with tlast set, one result is registered and leaves on m_axis:
//   tdata is the rank_k-th largest value (duplicates counted), tuser is 1 if
//   the set held at least rank_k values and rank_k is in 1..MAX_RANK; when
//   tuser is 0, tdata is 0. The list is then empty for the next set.
//   Throughput is one value per cycle while s_axis_tready is high, set by the
//   parallel insert across the cell row.
//   The cfg channel writes rank_k (always ready) and is to be used while idle.
//   Reset empties the list, drops pending results and sets rank_k to 1.
//   When m_axis stalls, results wait in an output register and a skid slot;
//   s_axis_tready drops only while both are full.
module kth_largest_select import kls_pkg::*; #(
  parameter int unsigned MAX_RANK = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // value requests
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [VALUE_W-1:0]  s_axis_tdata,   // [31:0] value
  input  logic                s_axis_tlast,   // last value of the set
  // results
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [VALUE_W-1:0]  m_axis_tdata,   // [31:0] kth_value
  output logic                m_axis_tuser,   // [0] enough
  // rank register write
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [RANK_W-1:0]   cfg_data_i      // [6:0] rank_k
);

  localparam int unsigned LNK_W = $clog2(MAX_RANK + 1);

  logic [RANK_W-1:0] rank_k_q;
  logic              accept;
  logic              room;
  logic              rank_ok;
  logic [LNK_W-1:0]  cur_idx, prev_idx;
  link_t             links [MAX_RANK+1];
  link_t             cur, prev;
  result_t           result;
  result_t           out_res;
  logic signed [VALUE_W-1:0] value;

  assign value         = $signed(s_axis_tdata);
  assign s_axis_tready = room;
  assign accept        = s_axis_tvalid & room;
  assign cfg_ready_o   = 1'b1;

  // Rank register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rank_k_q <= RANK_RESET;
    end else if (cfg_valid_i) begin
      rank_k_q <= cfg_data_i;
    end
  end

  // Head of the chain: accepts any value in front of slot 0
  assign links[0].keep  = 1'b1;
  assign links[0].valid = 1'b1;
  assign links[0].entry = '0;

  // Row of cells; links[i+1] is cell i
  for (genvar i = 0; i < MAX_RANK; i++) begin : g_cell
    kls_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .accept_i (accept),
      .clear_i  (s_axis_tlast),
      .value_i  (value),
      .prev_i   (links[i]),
      .link_o   (links[i+1])
    );
  end

  // Pick the post-insert content of slot rank_k-1 from the current cells
  assign rank_ok  = (rank_k_q != '0) &&
                    ({{(32-RANK_W){1'b0}}, rank_k_q} <= 32'(MAX_RANK));
  assign cur_idx  = rank_ok ? LNK_W'(rank_k_q) : LNK_W'(1);
  assign prev_idx = cur_idx - LNK_W'(1);
  assign cur      = links[cur_idx];
  assign prev     = links[prev_idx];

  always_comb begin
    result.enough    = rank_ok & (cur.valid | prev.valid);
    result.kth_value = '0;
    if (result.enough) begin
      if (cur.keep) begin
        result.kth_value = cur.entry;
      end else if (prev.keep) begin
        result.kth_value = value;
      end else begin
        result.kth_value = prev.entry;
      end
    end
  end

  kls_out_buf u_out_buf (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (accept & s_axis_tlast),
    .result_i (result),
    .room_o   (room),
    .valid_o  (m_axis_tvalid),
    .ready_i  (m_axis_tready),
    .result_o (out_res)
  );

  assign m_axis_tdata = out_res.kth_value;
  assign m_axis_tuser = out_res.enough;

endmodule

### hw/rtl/kls_cell.sv
// One slot of the sorted list: holds an entry and a valid bit, inserts by compare and shift.
// Depends on kls_pkg.
module kls_cell import kls_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      accept_i,  // value request taken this cycle
  input  logic                      clear_i,   // last value of the set: drop the list
  input  logic signed [VALUE_W-1:0] value_i,
  input  link_t                     prev_i,    // neighbor on the larger side
  output link_t                     link_o
);

  logic signed [VALUE_W-1:0] entry_q, entry_d;
  logic                      valid_q, valid_d;
  logic                      keep;

  // Entry stays if it is valid and not smaller than the incoming value
  assign keep = valid_q & (entry_q >= value_i);

  // Stay, take the new value, or take the neighbor's entry
  always_comb begin
    entry_d = entry_q;
    valid_d = valid_q;
    if (accept_i) begin
      if (keep) begin
        entry_d = entry_q;
      end else if (prev_i.keep) begin
        entry_d = value_i;
      end else begin
        entry_d = prev_i.entry;
      end
      valid_d = clear_i ? 1'b0 : (valid_q | prev_i.valid);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign link_o.keep  = keep;
  assign link_o.valid = valid_q;
  assign link_o.entry = entry_q;

endmodule

### hw/rtl/kls_out_buf.sv
// Output register with one skid slot for results of the k-th largest selector.
// Depends on kls_pkg.
module kls_out_buf import kls_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,    // new result this cycle
  input  result_t result_i,
  output logic    room_o,    // a new result can be taken
  output logic    valid_o,
  input  logic    ready_i,
  output result_t result_o
);

  result_t out_q, out_d, skid_q, skid_d;
  logic    out_valid_q, out_valid_d, skid_valid_q, skid_valid_d;
  logic    out_free;

  assign out_free = ~out_valid_q | ready_i;

  // Refill output from skid first, else from the new result
  always_comb begin
    out_d        = out_q;
    skid_d       = skid_q;
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    if (out_free) begin
      if (skid_valid_q) begin
        out_d        = skid_q;
        out_valid_d  = 1'b1;
        skid_valid_d = 1'b0;
      end else begin
        out_d       = result_i;
        out_valid_d = push_i;
      end
    end else if (push_i) begin
      skid_d       = result_i;
      skid_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign room_o   = ~skid_valid_q;
  assign valid_o  = out_valid_q;
  assign result_o = out_q;

endmodule

### verif/kls_checker.sv
// Scoreboard for the k-th largest selector: watches the value, result and rank channels.
// Keeps its own sorted list of the largest values per set and compares every result.
// Depends on kls_pkg.
module kls_checker import kls_pkg::*; #(
  parameter int unsigned MAX_RANK = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  input  logic                s_axis_tready,
  input  logic [VALUE_W-1:0]  s_axis_tdata,   // [31:0] value
  input  logic                s_axis_tlast,   // last value of the set
  input  logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  input  logic [VALUE_W-1:0]  m_axis_tdata,   // [31:0] kth_value
  input  logic                m_axis_tuser,   // [0] enough
  input  logic                cfg_valid_i,
  input  logic                cfg_ready_o,
  input  logic [RANK_W-1:0]   cfg_data_i,     // [6:0] rank_k
  output int unsigned         pending_o,
  output int unsigned         errors_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // predicted state of the selector
  logic signed [VALUE_W-1:0] top_vals [MAX_RANK];
  int unsigned               top_cnt;
  logic [RANK_W-1:0]         rank_q;

  result_t     kth_due_q [$];
  int unsigned err_cnt = 0;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t ns: %s: got %08h, expected %08h", $time, what, got, want);
    err_cnt++;
  endtask

  // compare-and-shift insert; entries equal to v stay ahead of it
  task automatic rank_insert(input logic signed [VALUE_W-1:0] v);
    int unsigned pos;
    int unsigned i;
    pos = 0;
    while (pos < top_cnt && top_vals[pos] >= v) pos++;
    if (pos < MAX_RANK) begin
      i = (top_cnt < MAX_RANK) ? top_cnt : MAX_RANK - 1;
      while (i > pos) begin
        top_vals[i] = top_vals[i-1];
        i--;
      end
      top_vals[pos] = v;
      if (top_cnt < MAX_RANK) top_cnt++;
    end
  endtask

  // result of a finished set under the current rank
  function automatic result_t kth_of_set();
    result_t r;
    if (rank_q >= 1 && rank_q <= MAX_RANK && top_cnt >= rank_q) begin
      r.enough    = 1'b1;
      r.kth_value = top_vals[rank_q-1];
    end else begin
      r.enough    = 1'b0;
      r.kth_value = '0;
    end
    return r;
  endfunction

  // results are checked before this edge's value is inserted
  always @(posedge clk_i or negedge rst_ni) begin
    result_t got;
    result_t want;
    if (!rst_ni) begin
      top_cnt = 0;
      rank_q  = RANK_RESET;
      kth_due_q.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_o) rank_q = cfg_data_i;
      if (m_axis_tvalid && m_axis_tready) begin
        got.kth_value = m_axis_tdata;
        got.enough    = m_axis_tuser;
        if (kth_due_q.size() == 0) begin
          report_mismatch("result with no finished set", m_axis_tdata, '0);
        end else begin
          want = kth_due_q.pop_front();
          if (got.kth_value !== want.kth_value)
            report_mismatch("kth_value", got.kth_value, want.kth_value);
          if (got.enough !== want.enough)
            report_mismatch("enough", 32'(got.enough), 32'(want.enough));
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        rank_insert(s_axis_tdata);
        if (s_axis_tlast) begin
          kth_due_q.push_back(kth_of_set());
          top_cnt = 0;
        end
      end
    end
    pending_o <= kth_due_q.size();
    errors_o  <= err_cnt;
  end

endmodule

### verif/testbench.sv
// Top of the k-th largest selector test: clock, reset, value and rank stimulus, verdict.
// Drives kth_largest_select and leaves prediction to kls_checker; depends on kls_pkg.
module testbench;
  import kls_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_RANK    = 64;
  localparam int unsigned VALUE_GOAL  = 1450;
  localparam int unsigned HOLD_CYCLES = 200;
  localparam int unsigned IDLE_LIMIT  = 2000;
  localparam int unsigned SETTLE      = 4;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               s_valid = 1'b0;
  logic               s_axis_tready;
  logic [VALUE_W-1:0] s_data = '0;
  logic               s_last = 1'b0;
  logic               m_axis_tvalid;
  logic               m_ready = 1'b0;
  logic [VALUE_W-1:0] m_axis_tdata;
  logic               m_axis_tuser;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready_o;
  logic [RANK_W-1:0]  cfg_data = '0;

  int unsigned pending;
  int unsigned errors;
  int unsigned values_sent = 0;
  int unsigned gap_max = 15;
  int unsigned rx_stall_max = 15;
  bit          hold_req = 1'b0;

  always #1 clk_i = ~clk_i;

  kth_largest_select #(.MAX_RANK(MAX_RANK)) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_data),
    .s_axis_tlast  (s_last),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data)
  );

  kls_checker #(.MAX_RANK(MAX_RANK)) u_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_data),
    .s_axis_tlast  (s_last),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data),
    .pending_o     (pending),
    .errors_o      (errors)
  );

  // mix of full-range values, small values that repeat, and the extremes
  function automatic logic [VALUE_W-1:0] pick_value();
    logic signed [VALUE_W-1:0] v;
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel < 5) begin
      v = $urandom();
    end else if (sel < 8) begin
      v = $urandom_range(0, 15);
      v = v - 8;
    end else if (sel < 9) begin
      case ($urandom_range(0, 3))
        0:       v = 32'h7FFF_FFFF;
        1:       v = 32'h8000_0000;
        2:       v = '0;
        default: v = 32'hFFFF_FFFF;
      endcase
    end else begin
      v = $urandom_range(0, 1) ? 32'h7FFF_FFFF - $urandom_range(0, 3)
                               : 32'h8000_0000 + $urandom_range(0, 3);
    end
    return v;
  endfunction

  // one value request; returns at the edge that accepts it
  task automatic send_value(input logic [VALUE_W-1:0] v, input logic last);
    int unsigned gap;
    gap = $urandom_range(0, gap_max);
    if (gap > 0) begin
      s_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_data  <= v;
    s_last  <= last;
    do @(posedge clk_i); while (!(s_valid && s_axis_tready));
    values_sent++;
  endtask

  task automatic send_set(input int unsigned n);
    for (int unsigned i = 0; i < n; i++) send_value(pick_value(), i == n - 1);
  endtask

  // sender pauses until every result of the finished sets has left
  task automatic wait_drained();
    s_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic write_rank(input logic [RANK_W-1:0] r);
    wait_drained();
    repeat (SETTLE) @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_data  <= r;
    do @(posedge clk_i); while (!(cfg_valid && cfg_ready_o));
    cfg_valid <= 1'b0;
  endtask

  // result receiver: random stall before each result, one long hold on request
  initial begin : rx_proc
    int unsigned stall;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      stall = $urandom_range(0, rx_stall_max);
      if (hold_req) begin
        hold_req = 1'b0;
        stall    = HOLD_CYCLES;
      end
      if (stall > 0) begin
        m_ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_ready <= 1'b1;
      do @(posedge clk_i); while (!(m_axis_tvalid && m_ready));
    end
  end

  // watchdog: fails the run after too many cycles without a transfer on any channel
  initial begin : watchdog
    int unsigned idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((s_valid && s_axis_tready) || (m_axis_tvalid && m_ready) ||
          (cfg_valid && cfg_ready_o))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("kth_largest_select test failed");
    $finish;
  end

  // stimulus and verdict
  initial begin : stim
    int unsigned pick;
    int unsigned r;
    int unsigned nsets;
    int unsigned n;
    int unsigned lo;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // rank 1 from reset: extremes, the minimum alone as maximum
    send_value(32'h8000_0000, 1'b1);
    send_value(32'h8000_0000, 1'b0);
    send_value(32'h7FFF_FFFF, 1'b0);
    send_value(32'h0000_0000, 1'b0);
    send_value(32'hFFFF_FFFF, 1'b1);
    // duplicates count toward the rank
    write_rank(RANK_W'(2));
    send_value(32'd5, 1'b0);
    send_value(32'd5, 1'b0);
    send_value(32'd5, 1'b1);
    send_value(-32'sd3, 1'b0);
    send_value(32'd9, 1'b0);
    send_value(32'd9, 1'b1);
    // fewer values than the rank
    write_rank(RANK_W'(3));
    send_value(32'd1, 1'b0);
    send_value(32'd2, 1'b1);
    write_rank(RANK_W'(MAX_RANK));
    send_value(32'd42, 1'b1);
    // rank zero and ranks beyond the list depth
    write_rank(RANK_W'(0));
    send_value(32'd7, 1'b1);
    write_rank(RANK_W'(MAX_RANK + 1));
    send_value(32'hFFFF_FFFF, 1'b0);
    send_value(32'h5555_5555, 1'b1);
    write_rank('1);
    send_value(32'hAAAA_AAAA, 1'b1);

    // long result hold while one-value sets keep coming: the input must stall
    write_rank(RANK_W'(1));
    gap_max  = 0;
    hold_req = 1'b1;
    for (int unsigned i = 0; i < 40; i++) send_set(1);

    // random phases: one rank per phase, set sizes mostly near the rank
    while (values_sent < VALUE_GOAL) begin
      pick = $urandom_range(0, 99);
      if (pick < 45)      r = $urandom_range(1, 4);
      else if (pick < 75) r = $urandom_range(5, 16);
      else if (pick < 85) r = $urandom_range(17, MAX_RANK - 1);
      else if (pick < 93) r = MAX_RANK;
      else                r = $urandom_range(0, 1) ? 0 : $urandom_range(MAX_RANK + 1, 127);
      write_rank(RANK_W'(r));
      gap_max      = ($urandom_range(0, 3) == 0) ? 0 : 15;
      rx_stall_max = ($urandom_range(0, 3) == 0) ? 0 : 15;
      nsets = (r > 16) ? $urandom_range(1, 2) : $urandom_range(2, 6);
      for (int unsigned s = 0; s < nsets; s++) begin
        pick = $urandom_range(0, 9);
        if (r >= 1 && r <= MAX_RANK && pick < 6) begin
          lo = (r > 2) ? r - 2 : 1;
          n  = $urandom_range(lo, r + 2);
        end else if (pick < 9) begin
          n = $urandom_range(1, 8);
        end else begin
          // more values than the list holds
          n = $urandom_range(MAX_RANK + 1, MAX_RANK + 16);
        end
        send_set(n);
      end
    end

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("kth_largest_select test passed");
    end else begin
      $display("kth_largest_select test failed");
    end
    $finish;
  end

endmodule
